/* hdl/anharmonic_bond_force_unit_defines.svh */
// Assertion macros used by the checker of the bond force unit.
// The macros expect signals named clk and rst_n in the scope that uses them.
`ifndef ANHARMONIC_BOND_FORCE_UNIT_DEFINES_SVH
`define ANHARMONIC_BOND_FORCE_UNIT_DEFINES_SVH

// A property that is checked only while the block is out of reset.
`define ABF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A property that is checked on every clock edge, reset included.
`define ABF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* hdl/abf_pkg.sv */
// Package of the anharmonic bond force unit: saturation and magnitude helpers.
// It depends on nothing; the top level takes it by scoped names.
`default_nettype none

package abf_pkg;

  localparam logic [63:0] MAG_MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_MAX_NEG = 64'h8000_0000_0000_0000;
  localparam logic [47:0] OUT_MAX     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] OUT_MIN     = 48'h8000_0000_0000;

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Signed 64-bit value from a 128-bit magnitude and a sign, clamped.
  function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input logic neg);
    logic [63:0] lim;
    logic [63:0] v;
    lim = neg ? MAG_MAX_NEG : MAG_MAX_POS;
    v = ((m[127:64] != '0) || (m[63:0] > lim)) ? lim : m[63:0];
    return neg ? $signed(64'(-v)) : $signed(v);
  endfunction

  // Saturating signed 64-bit add.
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? $signed(MAG_MAX_NEG) : $signed(MAG_MAX_POS);
    end
    return s[63:0];
  endfunction

  // Clamp a signed 64-bit value into 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (!v[63] && (v[62:47] != '0)) begin
      return $signed(OUT_MAX);
    end
    if (v[63] && (v[62:47] != '1)) begin
      return $signed(OUT_MIN);
    end
    return v[47:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/abf_mul.sv */
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Used by the bond force unit; it shares the unit's pipeline enable.
`default_nettype none

module abf_mul (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] p
);

  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01_r <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10_r <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11_r <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= 128'(pp00_r) + (128'(pp01_r) << 32) + (128'(pp10_r) << 32)
           + (128'(pp11_r) << 64);
    end
  end

endmodule

`default_nettype wire

/* hdl/anharmonic_bond_force_unit.sv */
// Channel  | direction | handshake          | word
// in_      | input     | in_valid/in_stall  | two positions, ideal length, force constant
// out_     | output    | out_valid/out_stall| force on A and B, bond energy
// cfg      | input     | APB write/read     | cubic and quartic coefficients
//
// One word is accepted every cycle unless a result is stalled at the output. The depth
// is set by the one-bit-a-stage square root and the one-bit-a-stage divider that scales
// each force component by 1/r.
// Reset is synchronous and clears the valid bits and the coefficients only.
// The whole pipeline holds while a result is stalled at the output, so nothing is lost.
// Top level of the anharmonic bond force unit; depends on abf_pkg and abf_mul.
`default_nettype none

module anharmonic_bond_force_unit #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_z,
  input  wire logic        [COORD_WIDTH-2:0] in_ideal_length,
  input  wire logic        [31:0]            in_spring_k,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [47:0]                 out_force_a_x,
  output logic signed [47:0]                 out_force_a_y,
  output logic signed [47:0]                 out_force_a_z,
  output logic signed [47:0]                 out_force_b_x,
  output logic signed [47:0]                 out_force_b_y,
  output logic signed [47:0]                 out_force_b_z,
  output logic signed [47:0]                 out_bond_energy,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = COORD_FRAC_BITS;
  localparam int DW  = W + 1;        // coordinate difference
  localparam int SW  = 2 * W + 4;    // sum of squares
  localparam int RW  = W + 2;        // distance
  localparam int DDW = RW + 1;       // distance minus ideal length
  localparam int QB  = F + 32;       // quotient bits kept by the divider

  // Stage indices. Each names the register bank that holds the value.
  localparam int S_SUM = 3;
  localparam int S_R   = S_SUM + RW;
  localparam int S_D   = S_R + 1;
  localparam int S_A   = S_D + 3;
  localparam int S_B   = S_A + 3;
  localparam int S_B1  = S_B + 1;
  localparam int S_B2  = S_B + 2;
  localparam int S_P   = S_B + 3;
  localparam int S_C   = S_P + 3;
  localparam int S_Q0  = S_C + 3;
  localparam int S_F   = S_Q0 + QB + 1;
  localparam int NS    = S_F + 1;

  localparam logic [63:0] ONE = 64'(1) << (F + 16);
  localparam logic [47:0] LIM47 = 48'h8000_0000_0000;

  // Configuration registers. The user's writes must come only while the pipeline is empty, unchecked by the block.
  logic signed [31:0] cubic_r, quartic_r;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? quartic_r : cubic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cubic_r   <= '0;
      quartic_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        quartic_r <= pwdata;
      end else begin
        cubic_r <= pwdata;
      end
    end
  end

  // The pipeline advances as a whole unless the result at the output is held.
  logic          en;
  logic [NS-1:0] v_r;

  assign en       = !(v_r[NS-1] && out_stall);
  assign in_stall = v_r[NS-1] && out_stall;
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // Payload registers, one entry per stage. Each value is produced at one
  // stage and then simply moves along with its word.
  logic signed [DW-1:0]  dlt_r  [NS][3];
  logic        [W-2:0]   len_r  [NS];
  logic        [31:0]    k_r    [NS];
  logic        [SW-1:0]  sum_r  [NS];
  logic        [RW:0]    rem_r  [NS];
  logic        [RW-1:0]  r_r    [NS];
  logic signed [DDW-1:0] d_r    [NS];
  logic signed [63:0]    d2_r   [NS];
  logic signed [63:0]    cd_r   [NS];
  logic signed [63:0]    qd2_r  [NS];
  logic signed [63:0]    kd2_r  [NS];
  logic signed [63:0]    kd_r   [NS];
  logic signed [63:0]    pe1_r  [NS];
  logic signed [63:0]    cd3_r  [NS];
  logic signed [63:0]    qq2_r  [NS];
  logic signed [63:0]    pe_r   [NS];
  logic signed [63:0]    pf1_r  [NS];
  logic signed [63:0]    pf_r   [NS];
  logic signed [63:0]    t2_r   [NS];
  logic signed [47:0]    eng_r  [NS];
  logic                  neg_r  [NS][3];
  logic                  sat_r  [NS][3];
  logic        [RW-1:0]  qrem_r [NS][3];
  logic        [QB-1:0]  nlo_r  [NS][3];
  logic        [QB-1:0]  quo_r  [NS][3];
  logic signed [47:0]    fa_r   [3];
  logic signed [47:0]    fb_r   [3];

  // Multiplier ports.
  logic [63:0]  sq_in [3];
  logic [127:0] sq_p  [3];
  logic [127:0] dd_p, cd_p, qd2_p, kd2_p, kd_p, e_p, t_p;
  logic [127:0] n_p   [3];
  logic [63:0]  t2_mag;

  assign t2_mag = abf_pkg::mag64(t2_r[S_C]);

  for (genvar i = 0; i < 3; i++) begin : g_axis_mul
    assign sq_in[i] = abf_pkg::mag64(64'(dlt_r[0][i]));
    abf_mul u_sq (.clk(clk), .en(en), .a(sq_in[i]), .b(sq_in[i]), .p(sq_p[i]));
    abf_mul u_n (
      .clk(clk), .en(en), .a(t2_mag),
      .b(abf_pkg::mag64(64'(dlt_r[S_C][i]))), .p(n_p[i])
    );
  end

  abf_mul u_dd (
    .clk(clk), .en(en), .a(abf_pkg::mag64(64'(d_r[S_D]))),
    .b(abf_pkg::mag64(64'(d_r[S_D]))), .p(dd_p)
  );
  abf_mul u_cd (
    .clk(clk), .en(en), .a(abf_pkg::mag64(64'(cubic_r))),
    .b(abf_pkg::mag64(64'(d_r[S_D]))), .p(cd_p)
  );
  abf_mul u_qd2 (
    .clk(clk), .en(en), .a(abf_pkg::mag64(64'(quartic_r))),
    .b(abf_pkg::mag64(d2_r[S_A])), .p(qd2_p)
  );
  abf_mul u_kd2 (
    .clk(clk), .en(en), .a(64'(k_r[S_A])), .b(abf_pkg::mag64(d2_r[S_A])), .p(kd2_p)
  );
  abf_mul u_kd (
    .clk(clk), .en(en), .a(64'(k_r[S_A])), .b(abf_pkg::mag64(64'(d_r[S_A]))), .p(kd_p)
  );
  abf_mul u_e (
    .clk(clk), .en(en), .a(abf_pkg::mag64(kd2_r[S_P])), .b(abf_pkg::mag64(pe_r[S_P])),
    .p(e_p)
  );
  abf_mul u_t (
    .clk(clk), .en(en), .a(abf_pkg::mag64(kd_r[S_P])), .b(abf_pkg::mag64(pf_r[S_P])),
    .p(t_p)
  );

  // Square root, one result bit per stage, restoring form.
  logic [RW:0]   sq_rem_nxt  [RW];
  logic [RW-1:0] sq_root_nxt [RW];

  always_comb begin
    logic [RW+2:0] cat;
    logic [RW+2:0] trial;
    for (int j = 0; j < RW; j++) begin
      cat   = {rem_r[S_SUM+j], sum_r[S_SUM+j][SW-1 -: 2]};
      trial = (RW+3)'({r_r[S_SUM+j], 2'b01});
      if (cat >= trial) begin
        sq_rem_nxt[j]  = (RW+1)'(cat - trial);
        sq_root_nxt[j] = {r_r[S_SUM+j][RW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[j]  = (RW+1)'(cat);
        sq_root_nxt[j] = {r_r[S_SUM+j][RW-2:0], 1'b0};
      end
    end
  end

  // Divider by r, one quotient bit per stage for each axis.
  logic [RW-1:0] dv_rem_nxt [QB][3];
  logic          dv_ge      [QB][3];

  always_comb begin
    logic [RW:0] trial;
    for (int j = 0; j < QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        trial = {qrem_r[S_Q0+j][i], nlo_r[S_Q0+j][i][QB-1]};
        dv_ge[j][i] = trial >= {1'b0, r_r[S_Q0+j]};
        dv_rem_nxt[j][i] = dv_ge[j][i] ? RW'(trial - {1'b0, r_r[S_Q0+j]}) : RW'(trial);
      end
    end
  end

  // Final scaling of each quotient to Q31.16 and the saturation of the force.
  logic signed [47:0] fa_nxt [3];
  logic signed [47:0] fb_nxt [3];

  always_comb begin
    logic [47:0] qs;
    logic [47:0] m;
    for (int i = 0; i < 3; i++) begin
      qs = 48'({quo_r[S_F-1][i], 16'b0} >> F);
      m  = (sat_r[S_F-1][i] || (qs > LIM47)) ? LIM47 : qs;
      if (r_r[S_F-1] == '0) begin
        fa_nxt[i] = '0;
      end else if (neg_r[S_F-1][i]) begin
        fa_nxt[i] = $signed(48'(-m));
      end else begin
        fa_nxt[i] = (m == LIM47) ? $signed(abf_pkg::OUT_MAX) : $signed(m);
      end
      fb_nxt[i] = (fa_nxt[i] == $signed(abf_pkg::OUT_MIN)) ? $signed(abf_pkg::OUT_MAX)
                                                             : 48'(-fa_nxt[i]);
    end
  end

  // Scaled multiplier results that feed the saturating conversions.
  logic [127:0] cd3_m, qq2_m, hi_n [3];

  assign cd3_m = ((128'(abf_pkg::mag64(cd_r[S_B])) << 1) + 128'(abf_pkg::mag64(cd_r[S_B])))
                 >> 1;
  assign qq2_m = 128'(abf_pkg::mag64(qd2_r[S_B])) << 1;

  for (genvar i = 0; i < 3; i++) begin : g_hi
    assign hi_n[i] = n_p[i] >> QB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Default: every value moves one stage on with its word.
      for (int s = 1; s < NS; s++) begin
        for (int i = 0; i < 3; i++) begin
          dlt_r[s][i]  <= dlt_r[s-1][i];
          neg_r[s][i]  <= neg_r[s-1][i];
          sat_r[s][i]  <= sat_r[s-1][i];
          qrem_r[s][i] <= qrem_r[s-1][i];
          nlo_r[s][i]  <= nlo_r[s-1][i];
          quo_r[s][i]  <= quo_r[s-1][i];
        end
        len_r[s] <= len_r[s-1];
        k_r[s]   <= k_r[s-1];
        sum_r[s] <= sum_r[s-1];
        rem_r[s] <= rem_r[s-1];
        r_r[s]   <= r_r[s-1];
        d_r[s]   <= d_r[s-1];
        d2_r[s]  <= d2_r[s-1];
        cd_r[s]  <= cd_r[s-1];
        qd2_r[s] <= qd2_r[s-1];
        kd2_r[s] <= kd2_r[s-1];
        kd_r[s]  <= kd_r[s-1];
        pe1_r[s] <= pe1_r[s-1];
        cd3_r[s] <= cd3_r[s-1];
        qq2_r[s] <= qq2_r[s-1];
        pe_r[s]  <= pe_r[s-1];
        pf1_r[s] <= pf1_r[s-1];
        pf_r[s]  <= pf_r[s-1];
        t2_r[s]  <= t2_r[s-1];
        eng_r[s] <= eng_r[s-1];
      end

      // Input stage: bond vector from A to B.
      dlt_r[0][0] <= DW'(in_b_x) - DW'(in_a_x);
      dlt_r[0][1] <= DW'(in_b_y) - DW'(in_a_y);
      dlt_r[0][2] <= DW'(in_b_z) - DW'(in_a_z);
      len_r[0]    <= in_ideal_length;
      k_r[0]      <= in_spring_k;

      // Squared length; the root iterations start from zero.
      sum_r[S_SUM] <= SW'(sq_p[0]) + SW'(sq_p[1]) + SW'(sq_p[2]);
      rem_r[S_SUM] <= '0;
      r_r[S_SUM]   <= '0;
      for (int j = 0; j < RW; j++) begin
        sum_r[S_SUM+j+1] <= sum_r[S_SUM+j] << 2;
        rem_r[S_SUM+j+1] <= sq_rem_nxt[j];
        r_r[S_SUM+j+1]   <= sq_root_nxt[j];
      end

      d_r[S_D] <= $signed(DDW'(r_r[S_R])) - $signed(DDW'(len_r[S_R]));

      d2_r[S_A] <= abf_pkg::sat_mag(dd_p >> F, 1'b0);
      cd_r[S_A] <= abf_pkg::sat_mag(cd_p, cubic_r[31] ^ d_r[S_A-1][DDW-1]);

      qd2_r[S_B] <= abf_pkg::sat_mag(qd2_p, quartic_r[31] ^ d2_r[S_B-1][63]);
      kd2_r[S_B] <= abf_pkg::sat_mag(kd2_p >> 8, d2_r[S_B-1][63]);
      kd_r[S_B]  <= abf_pkg::sat_mag(kd_p >> 8, d_r[S_B-1][DDW-1]);

      // Energy and force polynomials, one saturating add per stage.
      pe1_r[S_B1] <= abf_pkg::sadd64($signed(ONE), cd_r[S_B]);
      cd3_r[S_B1] <= abf_pkg::sat_mag(cd3_m, cd_r[S_B][63]);
      qq2_r[S_B1] <= abf_pkg::sat_mag(qq2_m, qd2_r[S_B][63]);
      pe_r[S_B2]  <= abf_pkg::sadd64(pe1_r[S_B1], qd2_r[S_B1]);
      pf1_r[S_B2] <= abf_pkg::sadd64($signed(ONE), cd3_r[S_B1]);
      pf_r[S_P]   <= abf_pkg::sadd64(pf1_r[S_B2], qq2_r[S_B2]);

      eng_r[S_C] <= abf_pkg::sat48(abf_pkg::sat_mag(e_p >> (2 * F),
                                                    kd2_r[S_C-1][63] ^ pe_r[S_C-1][63]));
      t2_r[S_C]  <= abf_pkg::sat_mag(t_p >> (F + 15), kd_r[S_C-1][63] ^ pf_r[S_C-1][63]);

      for (int i = 0; i < 3; i++) begin
        neg_r[S_C+1][i] <= t2_r[S_C][63] ^ dlt_r[S_C][i][DW-1];

        // A quotient that needs more than QB bits saturates the force.
        sat_r[S_Q0][i]  <= hi_n[i] >= 128'(r_r[S_Q0-1]);
        qrem_r[S_Q0][i] <= hi_n[i][RW-1:0];
        nlo_r[S_Q0][i]  <= n_p[i][QB-1:0];
        quo_r[S_Q0][i]  <= '0;
        for (int j = 0; j < QB; j++) begin
          qrem_r[S_Q0+j+1][i] <= dv_rem_nxt[j][i];
          nlo_r[S_Q0+j+1][i]  <= nlo_r[S_Q0+j][i] << 1;
          quo_r[S_Q0+j+1][i]  <= {quo_r[S_Q0+j][i][QB-2:0], dv_ge[j][i]};
        end

        fa_r[i] <= fa_nxt[i];
        fb_r[i] <= fb_nxt[i];
      end
    end
  end

  assign out_force_a_x   = fa_r[0];
  assign out_force_a_y   = fa_r[1];
  assign out_force_a_z   = fa_r[2];
  assign out_force_b_x   = fb_r[0];
  assign out_force_b_y   = fb_r[1];
  assign out_force_b_z   = fb_r[2];
  assign out_bond_energy = eng_r[S_F];

endmodule

`default_nettype wire

/* hdl/abf_chk.sv */
// Port-level checker of the bond force unit, bound to the top level below.
// Depends on the assertion macros in anharmonic_bond_force_unit_defines.svh.
`default_nettype none
`include "anharmonic_bond_force_unit_defines.svh"

module abf_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [47:0] out_force_a_x,
  input wire logic [47:0] out_force_b_x
);

  `ABF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `ABF_ASSERT(a_stall_source, in_stall |-> (out_valid && out_stall), "input stalled without cause")
  `ABF_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_force_a_x)), "stalled word changed")
  `ABF_ASSERT(a_neg_b, out_valid |-> ((out_force_b_x == 48'(-out_force_a_x)) || ((out_force_a_x == 48'h8000_0000_0000) && (out_force_b_x == 48'h7FFF_FFFF_FFFF))), "force on B is not the negation")

endmodule

bind anharmonic_bond_force_unit abf_chk u_abf_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_force_a_x(out_force_a_x),
  .out_force_b_x(out_force_b_x)
);

`default_nettype wire

/* bench/anharmonic_bond_force_unit_test.sv */
// Self-checking bench for the anharmonic bond force unit: directed table, then random bonds.
// Depends only on the unit's RTL; expected words come from a fixed-point predictor below.
`timescale 1ns / 100ps

module anharmonic_bond_force_unit_test;

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_WAIT  = 160;   // beyond the pipeline depth at the default widths
  localparam int  FRAC        = 20;
  localparam int  RAND_PER_PHASE = 128;

  // Register byte addresses of the configuration port.
  localparam logic [2:0] ADDR_CUBIC   = 3'd0;
  localparam logic [2:0] ADDR_QUARTIC = 3'd4;

  localparam logic [63:0] LIM47 = 64'h0000_8000_0000_0000;

  // One result word: force A x,y,z, force B x,y,z, energy.
  typedef logic [6:0][47:0] bond_result_t;

  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
    logic        [30:0] len;
    logic        [31:0] k;
    logic               typed;   // expected word typed in below
    bond_result_t       want;
  } bond_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic        [30:0] in_ideal_length = '0;
  logic        [31:0] in_spring_k = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] out_force_a_x, out_force_a_y, out_force_a_z;
  logic signed [47:0] out_force_b_x, out_force_b_y, out_force_b_z;
  logic signed [47:0] out_bond_energy;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  anharmonic_bond_force_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_ideal_length(in_ideal_length), .in_spring_k(in_spring_k),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_force_a_x(out_force_a_x), .out_force_a_y(out_force_a_y),
    .out_force_a_z(out_force_a_z), .out_force_b_x(out_force_b_x),
    .out_force_b_y(out_force_b_y), .out_force_b_z(out_force_b_z),
    .out_bond_energy(out_bond_energy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The bench keeps its own copy of the two coefficients.
  logic signed [31:0] cubic_now = '0;
  logic signed [31:0] quartic_now = '0;

  bond_result_t pending_words[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  settings_run = 0;
  int  cycles = 0;
  logic no_idle = 1'b0;   // when set, neither side inserts gaps

  // ---------------------------------------------------------------------
  // Predictor. Every clamped product is a magnitude product in 128 bits that
  // is shifted, truncated toward zero and clamped to the signed 64-bit range.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp_product(logic signed [63:0] a,
                                                      logic signed [63:0] b, int sh);
    logic [127:0] p;
    logic [63:0]  lim;
    logic [63:0]  v;
    logic         neg;
    neg = a[63] ^ b[63];
    p = ({64'b0, abs64(a)} * {64'b0, abs64(b)}) >> sh;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    v = (p > {64'b0, lim}) ? lim : p[63:0];
    return neg ? $signed(64'(-v)) : $signed(v);
  endfunction

  function automatic logic signed [63:0] add_clamped(logic signed [63:0] a,
                                                    logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? $signed(64'h8000_0000_0000_0000) : $signed(64'h7FFF_FFFF_FFFF_FFFF);
    end
    return s[63:0];
  endfunction

  function automatic logic [47:0] clamp_to_48(logic signed [63:0] v);
    if (v > $signed(LIM47 - 64'd1)) begin
      return 48'h7FFF_FFFF_FFFF;
    end
    if (v < -$signed(LIM47)) begin
      return 48'h8000_0000_0000;
    end
    return v[47:0];
  endfunction

  function automatic bond_result_t predict_bond(bond_word_t w);
    logic signed [63:0] dl[3];
    logic [127:0]       sum, num, q;
    logic [63:0]        root, cand, m;
    logic signed [63:0] d, d2, cd, qd2, unity, pe, pf, kd2, kd, t2, k, fa, fb;
    bond_result_t       res;
    dl[0] = 64'(w.bx) - 64'(w.ax);
    dl[1] = 64'(w.by) - 64'(w.ay);
    dl[2] = 64'(w.bz) - 64'(w.az);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      sum += {64'b0, abs64(dl[i])} * {64'b0, abs64(dl[i])};
    end
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'b0, cand} * {64'b0, cand} <= sum) begin
        root = cand;
      end
    end
    k = $signed({32'b0, w.k});
    d = $signed(root) - $signed({33'b0, w.len});
    d2 = clamp_product(d, d, FRAC);
    cd = clamp_product(64'(cubic_now), d, 0);
    qd2 = clamp_product(64'(quartic_now), d2, 0);
    unity = 64'sd1 <<< (FRAC + 16);
    pe = add_clamped(add_clamped(unity, cd), qd2);
    pf = add_clamped(add_clamped(unity, clamp_product(cd, 64'sd3, 1)),
                     clamp_product(qd2, 64'sd2, 0));
    kd2 = clamp_product(k, d2, 8);
    kd = clamp_product(k, d, 8);
    res[6] = clamp_to_48(clamp_product(kd2, pe, 2 * FRAC));
    t2 = clamp_product(kd, pf, FRAC + 15);
    for (int i = 0; i < 3; i++) begin
      if (root == '0) begin
        fa = '0;
      end else begin
        // Exact product and quotient, then the rescale from 20 to 16 fraction bits.
        num = {64'b0, abs64(t2)} * {64'b0, abs64(dl[i])};
        q = (num / {64'b0, root}) >> (FRAC - 16);
        m = (q > {64'b0, LIM47}) ? LIM47 : q[63:0];
        if (t2[63] ^ dl[i][63]) begin
          fa = -$signed(m);
        end else begin
          fa = (m > LIM47 - 64'd1) ? $signed(LIM47 - 64'd1) : $signed(m);
        end
      end
      // Force on B is the negation, with the most negative value clamped.
      fb = (fa == -$signed(LIM47)) ? $signed(LIM47 - 64'd1) : -fa;
      res[i] = fa[47:0];
      res[3 + i] = fb[47:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------
  task automatic write_coeff(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_CUBIC) begin
      cubic_now = value;
    end else begin
      quartic_now = value;
    end
  endtask

  // Waits until every expected word has come back, then lets the pipeline go quiet.
  task automatic drain_pipeline();
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_coefficients(logic [31:0] cubic, logic [31:0] quartic);
    drain_pipeline();
    write_coeff(ADDR_CUBIC, cubic);
    write_coeff(ADDR_QUARTIC, quartic);
    settings_run++;
  endtask

  task automatic send_bond(bond_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_x <= w.ax;
    in_a_y <= w.ay;
    in_a_z <= w.az;
    in_b_x <= w.bx;
    in_b_y <= w.by;
    in_b_z <= w.bz;
    in_ideal_length <= w.len;
    in_spring_k <= w.k;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_words.push_back(w.typed ? w.want : predict_bond(w));
    words_sent++;
  endtask

  // Mostly physical bonds: nearby atoms, lengths near a nanometer, moderate
  // constants. One word in five is raw noise over the full field ranges.
  function automatic bond_word_t random_bond();
    bond_word_t w;
    logic signed [31:0] base;
    w.typed = 1'b0;
    w.want = '0;
    if ($urandom_range(0, 4) == 0) begin
      w.ax = $urandom; w.ay = $urandom; w.az = $urandom;
      w.bx = $urandom; w.by = $urandom; w.bz = $urandom;
      w.len = 31'($urandom);
      w.k = $urandom;
    end else begin
      base = $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
      w.ax = base;
      w.ay = base + $signed($urandom_range(0, 32'h00FF_FFFF));
      w.az = base - $signed($urandom_range(0, 32'h00FF_FFFF));
      w.bx = w.ax + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w.by = w.ay + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w.bz = w.az + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w.len = 31'($urandom_range(0, 32'h0020_0000));
      w.k = $urandom_range(0, 32'h0FFF_FFFF);
    end
    return w;
  endfunction

  // Directed words: zero bonds, coincident atoms, the coordinate extremes in
  // both directions, a bond at its ideal length, stretched and compressed
  // bonds, and the largest constant and length that drive the outputs into
  // saturation. Only the plainly zero cases carry a typed expectation.
  bond_word_t directed_words[12] = '{
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 32'd0, 1'b1, '0},
    '{32'sd5, -32'sd7, 32'sd9, 32'sd5, -32'sd7, 32'sd9, 31'd0, 32'd0, 1'b1, '0},
    '{32'sd100, 32'sd100, 32'sd100, 32'sd100, 32'sd100, 32'sd100,
      31'h0010_0000, 32'hFFFF_FFFF, 1'b0, '0},
    '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
      -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
      31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sh0001_999A, 32'sd0, 32'sd0,
      31'h0001_999A, 32'h0005_0000, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sh0002_0000, 32'sd0,
      31'h0001_999A, 32'h0005_0000, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sh0001_0000,
      31'h0001_999A, 32'h0005_0000, 1'b0, '0},
    '{32'sh0010_0000, -32'sh0030_0000, 32'sh0005_0000,
      -32'sh0020_0000, 32'sh0011_0000, -32'sh0007_0000,
      31'h0008_0000, 32'h0100_0000, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 31'd0, 32'd1, 1'b0, '0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{-32'sh5555_5556, 32'sh2AAA_AAAA, -32'sd1, 32'sh5555_5555, -32'sh2AAA_AAAB,
      32'sd0, 31'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
  };

  // Coefficient pairs of the random phases: the extremes both ways round,
  // a physical pair, and two drawn at random.
  task automatic random_phase(logic [31:0] cubic, logic [31:0] quartic, logic quiet);
    set_coefficients(cubic, quartic);
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      // Every fourth stretch of sixteen words runs without gaps.
      no_idle = quiet || ((n / 16) % 4 == 3);
      send_bond(random_bond());
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
  endtask

  // Result side: a random stall before each word, none in the quiet stretches.
  initial begin : result_stalls
    int n;
    @(posedge rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(posedge clk);
      end while (!out_valid);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    bond_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_bond_energy, out_force_b_z, out_force_b_y, out_force_b_x,
             out_force_a_z, out_force_a_y, out_force_a_x};
      words_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t: result word arrived with nothing expected", $time);
        errors++;
      end else begin
        want = pending_words.pop_front();
        for (int i = 0; i < 7; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the coefficients at their reset value, then all but the
    // two typed words again with both coefficients at their most positive.
    settings_run = 1;
    foreach (directed_words[i]) begin
      send_bond(directed_words[i]);
    end
    in_valid <= 1'b0;
    set_coefficients(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 2; i < 12; i++) begin
      send_bond(directed_words[i]);
    end
    in_valid <= 1'b0;

    random_phase(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    random_phase(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    random_phase(32'hFFFE_0000, 32'h0003_0000, 1'b1);   // physical: -2/nm, 3/nm^2
    random_phase($urandom, $urandom, 1'b0);
    random_phase($urandom_range(0, 32'h0008_0000) - 32'h0004_0000, $urandom, 1'b0);

    drain_pipeline();
    $display("Sent %0d bond words, checked %0d results under %0d coefficient settings.",
             words_sent, words_seen, settings_run);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* anharmonic_bond_force_unit.f */
+incdir+hdl
hdl/abf_pkg.sv
hdl/abf_mul.sv
hdl/anharmonic_bond_force_unit.sv
hdl/abf_chk.sv
bench/anharmonic_bond_force_unit_test.sv
